[sv/cdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int OP_W   = 3;
    localparam int CAP_W  = 5;
    localparam int WORD_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY        = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic clear;
    } cmd_t;

endpackage : cdq_pkg
`default_nettype wire

[sv/cdq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: takes one beat, runs update, fetch and response phases.
// ----------------------------------------------------------------------------
module cdq_ctrl
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire logic         cfg_wr,
    output cdq_pkg::cmd_t     cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cdq_pkg::ST_EXEC;
                end
            end
            cdq_pkg::ST_EXEC:  state_next = cdq_pkg::ST_FETCH;
            cdq_pkg::ST_FETCH: state_next = cdq_pkg::ST_RESP;
            cdq_pkg::ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = cdq_pkg::ST_IDLE;
                end
            end
            default: state_next = cdq_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == cdq_pkg::ST_IDLE);
    assign out_valid = (state_reg == cdq_pkg::ST_RESP);

    assign cmd.load  = in_ready && in_valid;
    assign cmd.exec  = (state_reg == cdq_pkg::ST_EXEC);
    assign cmd.fetch = (state_reg == cdq_pkg::ST_FETCH);
    assign cmd.clear = cfg_wr;

endmodule : cdq_ctrl
`default_nettype wire

[sv/cdq_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_dpath
// Pointers, entry memory and result registers of the deque.
// ----------------------------------------------------------------------------
module cdq_dpath
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cdq_pkg::cmd_t                  cmd,
    input  wire logic [cdq_pkg::CAP_W-1:0]      capacity,
    input  wire logic [cdq_pkg::OP_W-1:0]       op,
    input  wire logic [cdq_pkg::WORD_W-1:0]     value,
    output logic                                ok,
    output logic [cdq_pkg::WORD_W-1:0]          front_value,
    output logic [cdq_pkg::WORD_W-1:0]          rear_value,
    output logic                                values_valid,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW0 = $clog2(DEPTH + 1);
    localparam int CW  = (CW0 > cdq_pkg::CAP_W) ? CW0 : cdq_pkg::CAP_W;

    logic [DATA_WIDTH-1:0] mem [0:DEPTH-1];

    logic [cdq_pkg::OP_W-1:0] op_reg;
    logic [DATA_WIDTH-1:0]    word_reg;
    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic                     empty_reg, empty_next;
    logic                     ok_reg, ok_next;
    logic                     full_reg;
    logic [DATA_WIDTH-1:0]    head_word_reg;
    logic [DATA_WIDTH-1:0]    tail_word_reg;

    logic                     wr_en;
    logic [IW-1:0]            wr_idx;
    logic [CW-1:0]            cap_ext;
    logic [CW-1:0]            cap_eff;
    logic                     full_now;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(i) + CW'(1);
        return (nxt >= cap) ? '0 : IW'(nxt);
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] wrap;
        wrap = cap - CW'(1);
        return (i == '0 || CW'(i) > cap) ? IW'(wrap) : i - IW'(1);
    endfunction

    // clamp capacity to 1..DEPTH
    assign cap_ext = CW'(capacity);
    assign cap_eff = (cap_ext == '0)        ? CW'(1) :
                     (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;

    assign full_now = !empty_reg && (step_up(tail_reg, cap_eff) == head_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ok_next    = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = '0;
        case (op_reg)
            cdq_pkg::OP_INSERT_FRONT, cdq_pkg::OP_INSERT_REAR:
            begin
                if (!full_now)
                begin
                    ok_next = 1'b1;
                    wr_en   = 1'b1;
                    if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        wr_idx     = '0;
                    end
                    else if (op_reg == cdq_pkg::OP_INSERT_FRONT)
                    begin
                        head_next = step_down(head_reg, cap_eff);
                        wr_idx    = head_next;
                    end
                    else
                    begin
                        tail_next = step_up(tail_reg, cap_eff);
                        wr_idx    = tail_next;
                    end
                end
            end
            cdq_pkg::OP_REMOVE_FRONT, cdq_pkg::OP_REMOVE_REAR:
            begin
                if (!empty_reg)
                begin
                    ok_next = 1'b1;
                    if (head_reg == tail_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (op_reg == cdq_pkg::OP_REMOVE_FRONT)
                    begin
                        head_next = step_up(head_reg, cap_eff);
                    end
                    else
                    begin
                        tail_next = step_down(tail_reg, cap_eff);
                    end
                end
            end
            cdq_pkg::OP_QUERY: ok_next = 1'b1;
            default:           ok_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            ok_reg    <= 1'b0;
            full_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
                ok_reg    <= ok_next;
            end
            if (cmd.fetch)
            begin
                full_reg <= full_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            word_reg <= DATA_WIDTH'(value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_idx] <= word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            head_word_reg <= mem[head_reg];
            tail_word_reg <= mem[tail_reg];
        end
    end

    assign ok           = ok_reg;
    assign front_value  = empty_reg ? '0 : cdq_pkg::WORD_W'(head_word_reg);
    assign rear_value   = empty_reg ? '0 : cdq_pkg::WORD_W'(tail_word_reg);
    assign values_valid = !empty_reg;
    assign is_empty     = empty_reg;
    assign is_full      = full_reg;

endmodule : cdq_dpath
`default_nettype wire

[sv/circular_deque_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue in a circular buffer with a programmable capacity.
// ----------------------------------------------------------------------------
// One operation per input beat (op on s_tuser, word on s_tdata) and one result
// beat per operation. Each beat passes through capture, pointer update with the
// entry write, a registered two-address read of the front and rear entries, and
// the result beat; the next beat is accepted after the result is taken. Writing
// the capacity register (APB, offset 0) empties the deque; a capacity of 0 acts
// as 1 and values above DEPTH act as DEPTH.
module circular_deque_unit
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [2:0]  s_tuser,   // [2:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] ok, [32:1] front_value, [64:33] rear_value, [65] is_empty,
    // [66] is_full, [71:67] zero
    output logic [71:0]      m_tdata,
    output logic             m_tuser,   // [0] values_valid
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [cdq_pkg::CAP_W-1:0]  capacity_reg;
    logic                       cfg_wr;
    logic                       cap_wr;
    cdq_pkg::cmd_t              cmd;

    logic                       ok;
    logic [cdq_pkg::WORD_W-1:0] front_value;
    logic [cdq_pkg::WORD_W-1:0] rear_value;
    logic                       values_valid;
    logic                       is_empty;
    logic                       is_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cap_wr = cfg_wr && (paddr[2] == cdq_pkg::REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cdq_pkg::CAP_RESET;
        end
        else if (cap_wr)
        begin
            capacity_reg <= pwdata[cdq_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == cdq_pkg::REG_CAPACITY) ? 32'(capacity_reg) : '0;

    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cfg_wr    (cap_wr),
        .cmd       (cmd)
    );

    cdq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .capacity     (capacity_reg),
        .op           (s_tuser),
        .value        (s_tdata),
        .ok           (ok),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .values_valid (values_valid),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    assign m_tdata = {5'd0, is_full, is_empty, rear_value, front_value, ok};
    assign m_tuser = values_valid;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and result sides active together");

    a_resp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##3 m_tvalid)
        else $error("result beat not presented three cycles after input beat");

    a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (is_empty != values_valid) && !(is_empty && is_full))
        else $error("empty, full and valid flags disagree");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cap_wr |=> is_empty)
        else $error("capacity write did not empty the deque");

endmodule : circular_deque_unit
`default_nettype wire

[sim/circular_deque_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit_tb
// Self-checking bench for the circular deque. A directed start walks the empty,
// full, last-entry and unknown-op cases. Random phases follow, all but the middle
// one under a new capacity setting. Every result beat is compared with a local
// model of the deque, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module circular_deque_unit_tb;

    localparam int          DEPTH         = 16;
    localparam int          IDX_W         = $clog2(DEPTH);
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_PHASES = 20;
    localparam int          PHASE_BEATS   = 100;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [2:0]  CAPACITY_ADDR = 3'd0;
    localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;
    localparam logic [2:0]  OP_FIRST_BAD  = 3'd5;
    localparam logic [2:0]  OP_LAST_BAD   = 3'd7;

    typedef struct packed {
        logic [cdq_pkg::OP_W-1:0]   op;
        logic [cdq_pkg::WORD_W-1:0] word;
    } deque_req_t;

    typedef struct packed {
        logic                       ok;
        logic [cdq_pkg::WORD_W-1:0] front;
        logic [cdq_pkg::WORD_W-1:0] rear;
        logic                       valid;
        logic                       empty;
        logic                       full;
    } deque_result_t;

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [31:0]   s_tdata   = '0;
    logic [2:0]    s_tuser   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [71:0]   m_tdata;
    logic          m_tuser;
    logic          psel      = 1'b0;
    logic          penable   = 1'b0;
    logic          pwrite    = 1'b0;
    logic [2:0]    paddr     = '0;
    logic [31:0]   pwdata    = '0;
    logic [31:0]   prdata;
    logic          pready;

    deque_req_t    pending_reqs[$];
    deque_result_t expected_results[$];

    // model state
    logic [cdq_pkg::WORD_W-1:0] slots [DEPTH];
    int unsigned                head_idx;
    int unsigned                tail_idx;
    logic                       deque_empty;
    logic [cdq_pkg::CAP_W-1:0]  cap_reg;

    int unsigned   errors       = 0;
    int unsigned   beats_seen   = 0;
    int unsigned   cycle_count  = 0;
    int unsigned   burst_left   = 0;
    int unsigned   gap_left     = 0;
    int unsigned   hold_left    = 0;
    int unsigned   next_hold_at = 300;
    int unsigned   mode_left    = 0;
    int unsigned   stall_mode   = 0;

    circular_deque_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned live_capacity();
        if (cap_reg == '0)
            return 1;
        if (cap_reg > DEPTH)
            return DEPTH;
        return 32'(cap_reg);
    endfunction

    function automatic int unsigned ring_next(int unsigned i, int unsigned cap);
        return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function automatic int unsigned ring_prev(int unsigned i, int unsigned cap);
        return (i == 0 || i > cap) ? cap - 1 : i - 1;
    endfunction

    function automatic logic deque_is_full(int unsigned cap);
        return !deque_empty && ring_next(tail_idx, cap) == head_idx;
    endfunction

    function automatic void clear_deque();
        deque_empty = 1'b1;
        head_idx    = 0;
        tail_idx    = 0;
    endfunction

    function automatic deque_result_t apply_op(logic [cdq_pkg::OP_W-1:0]   op,
                                               logic [cdq_pkg::WORD_W-1:0] word);
        int unsigned   cap;
        deque_result_t r;
        cap  = live_capacity();
        r.ok = 1'b0;
        case (op)
            cdq_pkg::OP_INSERT_FRONT, cdq_pkg::OP_INSERT_REAR:
            begin
                if (!deque_is_full(cap))
                begin
                    r.ok = 1'b1;
                    if (deque_empty)
                    begin
                        head_idx    = 0;
                        tail_idx    = 0;
                        deque_empty = 1'b0;
                        slots[0]    = word;
                    end
                    else if (op == cdq_pkg::OP_INSERT_FRONT)
                    begin
                        head_idx                    = ring_prev(head_idx, cap);
                        slots[head_idx[IDX_W-1:0]]  = word;
                    end
                    else
                    begin
                        tail_idx                    = ring_next(tail_idx, cap);
                        slots[tail_idx[IDX_W-1:0]]  = word;
                    end
                end
            end
            cdq_pkg::OP_REMOVE_FRONT, cdq_pkg::OP_REMOVE_REAR:
            begin
                if (!deque_empty)
                begin
                    r.ok = 1'b1;
                    if (head_idx == tail_idx)
                        clear_deque();
                    else if (op == cdq_pkg::OP_REMOVE_FRONT)
                        head_idx = ring_next(head_idx, cap);
                    else
                        tail_idx = ring_prev(tail_idx, cap);
                end
            end
            cdq_pkg::OP_QUERY:
                r.ok = 1'b1;
            default:
                r.ok = 1'b0;
        endcase
        r.front = deque_empty ? '0 : slots[head_idx[IDX_W-1:0]];
        r.rear  = deque_empty ? '0 : slots[tail_idx[IDX_W-1:0]];
        r.valid = !deque_empty;
        r.empty = deque_empty;
        r.full  = deque_is_full(cap);
        return r;
    endfunction

    // sender: bursts of random length, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        deque_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(), apply_op(s_tuser, s_tdata));
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.op;
                    s_tdata  <= req.word;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall modes plus a periodic long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (beats_seen >= next_hold_at)
        begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + 900;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 80);
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        deque_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen = beats_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp = expected_results.pop_front();
                check_field("ok",           32'(exp.ok),    32'(m_tdata[0]));
                check_field("front_value",  exp.front,      m_tdata[32:1]);
                check_field("rear_value",   exp.rear,       m_tdata[64:33]);
                check_field("values_valid", 32'(exp.valid), 32'(m_tuser));
                check_field("is_empty",     32'(exp.empty), 32'(m_tdata[65]));
                check_field("is_full",      32'(exp.full),  32'(m_tdata[66]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("circular_deque_unit_tb: errors");
            $finish;
        end
    end

    task automatic add_req(logic [cdq_pkg::OP_W-1:0] op, logic [cdq_pkg::WORD_W-1:0] word);
        deque_req_t req;
        req.op   = op;
        req.word = word;
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == cdq_pkg::REG_CAPACITY)
        begin
            cap_reg = data[cdq_pkg::CAP_W-1:0];
            clear_deque();
        end
    endtask

    function automatic logic [31:0] capacity_word(logic [cdq_pkg::CAP_W-1:0] cap);
        logic [31:0] w;
        w = $urandom;
        w[cdq_pkg::CAP_W-1:0] = cap;
        return w;
    endfunction

    initial
    begin
        int unsigned               ins_pct;
        int unsigned               pick;
        int unsigned               cap_pick;
        logic [cdq_pkg::CAP_W-1:0] cap;
        logic [31:0]               word;

        cap_reg = cdq_pkg::CAP_RESET;
        clear_deque();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque, both ends, last-entry removal, unknown ops
        add_req(cdq_pkg::OP_QUERY,        $urandom);
        add_req(cdq_pkg::OP_REMOVE_FRONT, $urandom);
        add_req(cdq_pkg::OP_REMOVE_REAR,  $urandom);
        add_req(OP_FIRST_BAD,             $urandom);
        add_req(cdq_pkg::OP_INSERT_REAR,  32'hFFFF_FFFF);
        add_req(cdq_pkg::OP_INSERT_FRONT, 32'h0000_0000);
        add_req(cdq_pkg::OP_INSERT_REAR,  32'hA5A5_5A5A);
        add_req(cdq_pkg::OP_QUERY,        $urandom);
        add_req(cdq_pkg::OP_REMOVE_REAR,  $urandom);
        add_req(cdq_pkg::OP_REMOVE_FRONT, $urandom);
        add_req(cdq_pkg::OP_REMOVE_FRONT, $urandom);
        add_req(OP_LAST_BAD,              $urandom);
        add_req(cdq_pkg::OP_INSERT_FRONT, 32'h0000_0001);
        add_req(cdq_pkg::OP_REMOVE_REAR,  $urandom);
        wait_idle();

        // zero capacity acts as one: full after a single insert
        apb_write(CAPACITY_ADDR, capacity_word('0));
        add_req(cdq_pkg::OP_INSERT_REAR,  32'h8000_0000);
        add_req(cdq_pkg::OP_INSERT_FRONT, 32'h1234_5678);
        add_req(cdq_pkg::OP_INSERT_REAR,  32'h1234_5678);
        add_req(OP_FIRST_BAD + 3'd1,      $urandom);
        add_req(cdq_pkg::OP_REMOVE_FRONT, $urandom);
        add_req(cdq_pkg::OP_INSERT_FRONT, 32'h7FFF_FFFF);
        add_req(cdq_pkg::OP_REMOVE_REAR,  $urandom);
        add_req(cdq_pkg::OP_REMOVE_REAR,  $urandom);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            cap_pick = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                                    : $urandom_range(0, 31);
            case (phase)
                0:       cap = cdq_pkg::CAP_RESET;
                1:       cap = '1;
                2:       cap = cdq_pkg::CAP_RESET + 5'd1;
                3:       cap = 5'd1;
                4:       cap = '0;
                5:       cap = 5'd2;
                default: cap = cap_pick[cdq_pkg::CAP_W-1:0];
            endcase
            // a write outside the register map must leave the deque alone
            if (phase == RANDOM_PHASES / 2)
                apb_write(UNMAPPED_ADDR, $urandom);
            else
                apb_write(CAPACITY_ADDR, capacity_word(cap));

            ins_pct = $urandom_range(25, 65);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 15))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                if (pick < ins_pct)
                    add_req($urandom_range(0, 1) ? cdq_pkg::OP_INSERT_REAR
                                                 : cdq_pkg::OP_INSERT_FRONT, word);
                else if (pick < 91)
                    add_req($urandom_range(0, 1) ? cdq_pkg::OP_REMOVE_REAR
                                                 : cdq_pkg::OP_REMOVE_FRONT, word);
                else if (pick < 97)
                    add_req(cdq_pkg::OP_QUERY, word);
                else
                begin
                    pick = $urandom_range(OP_FIRST_BAD, OP_LAST_BAD);
                    add_req(pick[cdq_pkg::OP_W-1:0], word);
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("circular_deque_unit_tb: clean");
        else
            $display("circular_deque_unit_tb: errors");
        $finish;
    end

endmodule
